/* design/mbql_pkg.sv */
`default_nettype none
package mbql_pkg;
    localparam int N_STATES  = 64;
    localparam int N_ACTIONS = 3;
    localparam int SW = 6;
    localparam int AW = 2;
    localparam int P_DEPTH = N_STATES * N_STATES * N_ACTIONS;
    localparam int Q_DEPTH = N_STATES * N_ACTIONS;
    localparam int PAW = $clog2(P_DEPTH);
    localparam int QAW = $clog2(Q_DEPTH);
    localparam int PW = 16;
    localparam int QW = 24;

    localparam logic [1:0] CFG_LR   = 2'd0;
    localparam logic [1:0] CFG_DISC = 2'd1;
    localparam logic [1:0] CFG_STEP = 2'd2;

    localparam logic [8:0] LR_RESET   = 9'd51;
    localparam logic [8:0] DISC_RESET = 9'd205;
    localparam logic [7:0] STEP_RESET = 8'd26;

    typedef logic [PAW-1:0] t_paddr;
    typedef logic [QAW-1:0] t_qaddr;

    // round half up then arithmetic shift by 8
    function automatic logic signed [40:0] rnd8(input logic signed [40:0] x);
        logic signed [40:0] y;
        y = x + 41'sd128;
        return y >>> 8;
    endfunction

    function automatic logic signed [QW-1:0] sat24(input logic signed [40:0] x);
        if (x > 41'sd8388607) return 24'sh7FFFFF;
        else if (x < -41'sd8388608) return 24'sh800000;
        else return x[QW-1:0];
    endfunction

    function automatic logic signed [PW-1:0] sat16(input logic signed [17:0] x);
        if (x > 18'sd32767) return 16'sh7FFF;
        else if (x < -18'sd32768) return 16'sh8000;
        else return x[PW-1:0];
    endfunction
endpackage
`default_nettype wire

/* design/mbql_ram.sv */
`default_nettype none
module mbql_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

/* design/model_based_q_learning_agent_core.sv */
// items: a new item is taken only when idle, once the previous result is in the output register;
//   the serial score scan makes one read per cycle over next states for each action;
//   a result waiting for a still-valid output register stalls input
// reset: synchronous active low; afterwards a clearing pass over all P_DEPTH addresses
//   zeroes both memories before the first item is taken
`default_nettype none
module model_based_q_learning_agent_core
    import mbql_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    output logic                      o_stall,
    input  wire logic                 i_mode,
    input  wire logic [SW-1:0]        i_state_index,
    input  wire logic [AW-1:0]        i_action_index,
    input  wire logic [SW-1:0]        i_new_state,
    input  wire logic signed [7:0]    i_reward,
    input  wire logic                 i_episode_done,
    input  wire logic                 i_random_pick,
    input  wire logic [AW-1:0]        i_random_action,
    output logic                      o_valid,
    input  wire logic                 i_stall,
    output logic [AW-1:0]             o_chosen_action,
    output logic [SW-1:0]             o_predicted_state,
    output logic signed [QW-1:0]      o_q_value,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [1:0]           i_cfg_index,
    input  wire logic [8:0]           i_cfg_data
);
    localparam logic [3:0] ST_CLEAR = 4'd0;
    localparam logic [3:0] ST_IDLE  = 4'd1;
    localparam logic [3:0] ST_SCAN  = 4'd2;
    localparam logic [3:0] ST_SDONE = 4'd3;
    localparam logic [3:0] ST_QRD   = 4'd4;
    localparam logic [3:0] ST_QWT   = 4'd5;
    localparam logic [3:0] ST_PUPD  = 4'd6;
    localparam logic [3:0] ST_MAXQ  = 4'd7;
    localparam logic [3:0] ST_TD1   = 4'd8;
    localparam logic [3:0] ST_TD2   = 4'd9;
    localparam logic [3:0] ST_OUT   = 4'd10;
    localparam logic [3:0] ST_PUP2  = 4'd11;

    logic [3:0] r_st, n_st;
    logic [PAW:0] r_clr;
    logic [8:0] r_lr, r_disc;
    logic [7:0] r_step;

    // item fields
    logic r_mode, r_done, r_rpick;
    logic [SW-1:0] r_s, r_ns;
    logic [AW-1:0] r_act, r_ract, r_a;
    logic signed [7:0] r_rew;

    // scan state
    logic [SW:0] r_n;              // issue counter
    logic [SW-1:0] r_rn;           // index of data returning
    logic r_rv;
    logic signed [PW-1:0] r_bestv;
    logic [SW-1:0] r_best;
    logic [SW-1:0] r_preds [N_ACTIONS];
    logic signed [QW-1:0] r_bestq;
    logic [AW-1:0] r_besta;
    logic [AW:0] r_qi;
    logic signed [QW-1:0] r_maxq, r_q;
    logic signed [40:0] r_diff;
    logic signed [PW-1:0] r_pv;

    // td terms and kept q values
    logic signed [40:0] disc_term;
    logic signed [QW-1:0] r_qlast;
    logic signed [QW-1:0] r_qs [N_ACTIONS];
    logic signed [QW-1:0] sel_q;

    // output register
    logic r_ov;
    logic [AW-1:0] r_oa;
    logic [SW-1:0] r_op;
    logic signed [QW-1:0] r_oq;

    // memory ports
    logic p_we, q_we;
    t_paddr p_wa, p_ra;
    t_qaddr q_wa, q_ra;
    logic [PW-1:0] p_wd, p_rd;
    logic [QW-1:0] q_wd, q_rd;

    mbql_ram #(.WIDTH(PW), .DEPTH(P_DEPTH)) u_p (
        .i_clk(i_clk), .i_we(p_we), .i_waddr(p_wa), .i_wdata(p_wd),
        .i_raddr(p_ra), .o_rdata(p_rd));
    mbql_ram #(.WIDTH(QW), .DEPTH(Q_DEPTH)) u_q (
        .i_clk(i_clk), .i_we(q_we), .i_waddr(q_wa), .i_wdata(q_wd),
        .i_raddr(q_ra), .o_rdata(q_rd));

    function automatic t_paddr paddr(input logic [SW-1:0] s, input logic [SW-1:0] n,
                                     input logic [AW-1:0] a);
        return t_paddr'((PAW+1)'(s) * (PAW+1)'(N_STATES * N_ACTIONS)
                      + (PAW+1)'(n) * (PAW+1)'(N_ACTIONS) + (PAW+1)'(a));
    endfunction
    function automatic t_qaddr qaddr(input logic [SW-1:0] s, input logic [AW-1:0] a);
        return t_qaddr'((QAW+1)'(s) * (QAW+1)'(N_ACTIONS) + (QAW+1)'(a));
    endfunction
    function automatic logic [AW-1:0] amod(input logic [AW-1:0] a);
        return (32'(a) >= N_ACTIONS) ? AW'(32'(a) - N_ACTIONS) : a;
    endfunction

    assign o_stall = (r_st != ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_valid = r_ov;
    assign o_chosen_action = r_oa;
    assign o_predicted_state = r_op;
    assign o_q_value = r_oq;

    logic in_acc;
    assign in_acc = i_valid && !o_stall;

    logic signed [17:0] pv_up, pv_dn;
    assign pv_up = 18'(r_pv) + 18'sd0 + $signed({10'd0, r_step});
    assign pv_dn = 18'(r_pv) - $signed({10'd0, r_step});
    logic [SW-1:0] sel_pred;
    assign sel_pred = r_preds[r_rpick ? amod(r_ract) : r_besta];
    logic [AW-1:0] sel_act;
    assign sel_act = r_rpick ? amod(r_ract) : r_besta;

    // memory addressing
    always_comb begin
        p_we = 1'b0; p_wa = '0; p_wd = '0; p_ra = paddr(r_s, r_n[SW-1:0], r_a);
        q_we = 1'b0; q_wa = '0; q_wd = '0; q_ra = '0;
        case (r_st)
            ST_CLEAR: begin
                p_we = 1'b1; p_wa = r_clr[PAW-1:0];
                q_we = (r_clr < (PAW+1)'(Q_DEPTH)); q_wa = r_clr[QAW-1:0];
            end
            ST_QRD: begin
                q_ra = r_mode ? qaddr(r_ns, r_qi[AW-1:0])
                              : qaddr(r_preds[r_qi[AW-1:0]], r_qi[AW-1:0]);
                p_ra = paddr(r_s, r_best, r_a);
            end
            ST_PUPD: begin
                p_we = 1'b1; p_wa = paddr(r_s, r_best, r_a);
                p_wd = (r_best == r_ns) ? sat16(pv_up) : sat16(pv_dn);
                p_ra = paddr(r_s, r_ns, r_a);
                q_ra = qaddr(r_ns, r_qi[AW-1:0]);
            end
            ST_PUP2: begin
                p_we = 1'b1; p_wa = paddr(r_s, r_ns, r_a);
                p_wd = sat16(18'(signed'(p_rd)) + $signed({10'd0, r_step}));
                q_ra = qaddr(r_ns, r_qi[AW-1:0]);
            end
            ST_MAXQ: q_ra = (r_qi < (AW+1)'(N_ACTIONS)) ? qaddr(r_ns, r_qi[AW-1:0])
                                                          : qaddr(r_s, r_a);
            ST_TD2: begin
                q_we = 1'b1; q_wa = qaddr(r_s, r_a);
                q_wd = r_done ? QW'({{8{r_rew[7]}}, r_rew, 8'd0})
                              : sat24(41'(r_q) + rnd8(r_diff * $signed({32'd0, r_lr})));
            end
            default: ;
        endcase
    end

    // control sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= ST_CLEAR; r_clr <= '0; r_ov <= 1'b0;
            r_lr <= LR_RESET; r_disc <= DISC_RESET; r_step <= STEP_RESET;
            r_rv <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_LR:   r_lr <= i_cfg_data;
                    CFG_DISC: r_disc <= i_cfg_data;
                    CFG_STEP: r_step <= i_cfg_data[7:0];
                    default: ;
                endcase
            end
            if (r_ov && !i_stall) r_ov <= 1'b0;
            r_rv <= 1'b0;
            case (r_st)
                ST_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == (PAW+1)'(P_DEPTH - 1)) r_st <= ST_IDLE;
                end
                ST_IDLE: if (in_acc) begin
                    r_mode <= i_mode; r_s <= i_state_index; r_ns <= i_new_state;
                    r_act <= amod(i_action_index); r_rew <= i_reward;
                    r_done <= i_episode_done; r_rpick <= i_random_pick;
                    r_ract <= i_random_action;
                    r_a <= i_mode ? amod(i_action_index) : '0;
                    r_n <= '0; r_bestq <= '0; r_besta <= '0;
                    r_st <= ST_SCAN;
                end
                // one score per cycle, running first-max compare
                ST_SCAN: begin
                    if (r_rv) begin
                        if (r_rn == '0 || signed'(p_rd) > r_bestv) begin
                            r_bestv <= signed'(p_rd); r_best <= r_rn;
                        end
                    end
                    if (r_n < (SW+1)'(N_STATES)) begin
                        r_rv <= 1'b1; r_rn <= r_n[SW-1:0]; r_n <= r_n + 1'b1;
                    end else if (!r_rv) begin
                        r_st <= ST_SDONE;
                    end
                end
                ST_SDONE: begin
                    r_preds[r_a] <= r_best;
                    r_qi <= r_mode ? '0 : (AW+1)'(r_a);
                    r_st <= ST_QRD;
                end
                ST_QRD: r_st <= ST_QWT;
                ST_QWT: begin
                    if (r_mode) begin
                        r_pv <= signed'(p_rd);
                        r_st <= ST_PUPD;
                    end else begin
                        if (r_a == '0 || signed'(q_rd) > r_bestq) begin
                            r_bestq <= signed'(q_rd); r_besta <= r_a;
                        end
                        if (32'(r_a) == N_ACTIONS - 1) begin
                            r_st <= ST_OUT;
                        end else begin
                            r_a <= r_a + 1'b1; r_n <= '0; r_st <= ST_SCAN;
                        end
                    end
                end
                ST_PUPD: begin
                    r_st <= (r_best == r_ns) ? ST_MAXQ : ST_PUP2;
                    r_qi <= '0;
                end
                ST_PUP2: r_st <= ST_MAXQ;
                // q reads pipelined one per cycle, last one is Q(s,a)
                ST_MAXQ: begin
                    if (r_rv) begin
                        if (r_qi == (AW+1)'(1) || signed'(q_rd) > r_maxq)
                            r_maxq <= signed'(q_rd);
                    end
                    r_rv <= 1'b1;
                    r_qi <= r_qi + 1'b1;
                    if (r_qi == (AW+1)'(N_ACTIONS)) begin
                        r_st <= ST_TD1;
                    end
                end
                ST_TD1: begin
                    r_q <= signed'(q_rd);
                    r_st <= ST_TD2;
                end
                ST_TD2: r_st <= ST_OUT;
                ST_OUT: if (!r_ov) begin
                    r_ov <= 1'b1;
                    if (r_mode) begin
                        r_oa <= r_act; r_op <= r_best; r_oq <= r_qlast;
                    end else begin
                        r_oa <= sel_act; r_op <= sel_pred; r_oq <= sel_q;
                    end
                    r_st <= ST_IDLE;
                end
                default: r_st <= ST_IDLE;
            endcase
        end
    end

    // diff register for td step
    assign disc_term = rnd8(41'(r_maxq) * $signed({32'd0, r_disc}));
    always_ff @(posedge i_clk) begin
        if (r_st == ST_TD1) begin
            r_diff <= $signed({{25{r_rew[7]}}, r_rew, 8'd0}) + disc_term
                      - 41'(signed'(q_rd));
        end
    end

    // written q kept for the result
    always_ff @(posedge i_clk) begin
        if (q_we && r_st == ST_TD2) r_qlast <= q_wd;
    end

    // q of chosen action: recorded per action during choose
    always_ff @(posedge i_clk) begin
        if (r_st == ST_QWT && !r_mode) r_qs[r_a] <= signed'(q_rd);
    end
    assign sel_q = r_qs[sel_act];

`ifndef SYNTHESIS
    a_no_in_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st != ST_IDLE) |-> o_stall) else $error("accept while busy");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_q_value))) else $error("out dropped");
    a_clear_mem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == ST_CLEAR) |-> (p_we && !o_valid)) else $error("clear pass");
`endif
endmodule
`default_nettype wire
